/* src/merge_and_scale_intervals_defines.svh */
// Assertion macros shared by the merge_and_scale_intervals RTL.
// No dependencies; modules using these must have clk and rst_n in scope.
`ifndef MERGE_AND_SCALE_INTERVALS_DEFINES_SVH
`define MERGE_AND_SCALE_INTERVALS_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MSI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("msi: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define MSI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("msi: next-cycle check failed");

`endif

/* src/msi_pkg.sv */
// Shared types and constants for merge_and_scale_intervals.
// No dependencies.
package msi_pkg;

  localparam int COORD_W = 32;
  localparam int SCALE_W = 16;
  localparam int CNT_W   = $clog2(COORD_W);

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_FLUSH,
    ST_GAP,
    ST_GWAIT,
    ST_LEN,
    ST_LWAIT,
    ST_OUT
  } state_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic capture;    // latch the incoming transaction
    logic upd_end;    // merge: open end takes the larger end
    logic install;    // pending interval becomes the open one
    logic ld_emit;    // copy open interval into the emit registers
    logic emit_last;  // flag loaded alongside ld_emit
    logic gap_start;  // start divider on the gap
    logic gap_cap;    // capture scaled gap and scaled start
    logic len_start;  // start divider on the length
    logic len_cap;    // capture ceiled scaled length
    logic out_load;   // load output register, advance chained state
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic merge;      // pending overlaps or touches the open interval
    logic open_valid;
    logic pend_last;
    logic emit_last;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

/* src/msi_div.sv */
// Radix-2 restoring divider, 32-bit dividend by 16-bit divisor, one bit a cycle.
// Depends on msi_pkg.
module msi_div
  import msi_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [COORD_W-1:0] dividend,
  input  logic [SCALE_W-1:0] divisor,
  output logic               busy,
  output logic               done,
  output logic [COORD_W-1:0] quotient,
  output logic [SCALE_W-1:0] remainder
);

  logic [COORD_W-1:0] q_r;
  logic [SCALE_W-1:0] rem_r;
  logic [SCALE_W-1:0] dvsr_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               done_r;

  logic [SCALE_W:0]   trial;
  logic [SCALE_W:0]   diff;
  logic               ge;

  assign trial = {rem_r, q_r[COORD_W-1]};
  assign ge    = (trial >= {1'b0, dvsr_r});
  assign diff  = trial - {1'b0, dvsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(COORD_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r    <= dividend;
      rem_r  <= '0;
      dvsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[SCALE_W-1:0] : trial[SCALE_W-1:0];
      q_r   <= {q_r[COORD_W-2:0], ge};
    end
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

/* src/msi_dp.sv */
// Datapath: pending and open intervals, chained state, divider, output register.
// Depends on msi_pkg, msi_div and merge_and_scale_intervals_defines.svh.
`include "merge_and_scale_intervals_defines.svh"

module msi_dp
  import msi_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic               cfg_wr_en,
  input  logic [SCALE_W-1:0] cfg_scale_divisor,
  input  logic [COORD_W-1:0] in_interval_start,
  input  logic [COORD_W-1:0] in_interval_end,
  input  logic               in_is_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COORD_W-1:0] out_merged_start,
  output logic [COORD_W-1:0] out_merged_end,
  output logic [COORD_W-1:0] out_scaled_gap,
  output logic [COORD_W-1:0] out_scaled_length,
  output logic [COORD_W-1:0] out_scaled_start,
  output logic [COORD_W-1:0] out_scaled_end,
  output logic               out_last_out
);

  logic [SCALE_W-1:0] scale_r;
  logic [COORD_W-1:0] pend_s_r, pend_e_r;
  logic               pend_last_r;
  logic [COORD_W-1:0] open_s_r, open_e_r;
  logic               open_valid_r;
  logic [COORD_W-1:0] prev_me_r, prev_se_r;
  logic [COORD_W-1:0] emit_s_r, emit_e_r;
  logic               emit_last_r;
  logic [COORD_W-1:0] sgap_r, slen_r, sstart_r;
  logic               out_valid_r;
  logic [COORD_W-1:0] o_ms_r, o_me_r, o_gap_r, o_len_r, o_ss_r, o_se_r;
  logic               o_last_r;

  logic [SCALE_W-1:0] eff_div;
  logic [COORD_W-1:0] div_dividend;
  logic [COORD_W-1:0] div_q;
  logic [SCALE_W-1:0] div_rem;
  logic               div_busy, div_done;
  logic               out_free;
  logic [COORD_W-1:0] send;

  // scale of zero behaves as one
  assign eff_div      = (scale_r == '0) ? SCALE_W'(1) : scale_r;
  assign div_dividend = cmd.len_start ? (emit_e_r - emit_s_r) : (emit_s_r - prev_me_r);
  assign out_free     = !out_valid_r || out_ready;
  assign send         = sstart_r + slen_r;

  msi_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.gap_start || cmd.len_start),
    .dividend  (div_dividend),
    .divisor   (eff_div),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  // control and chained state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r      <= SCALE_RESET;
      open_valid_r <= 1'b0;
      open_s_r     <= '0;
      open_e_r     <= '0;
      prev_me_r    <= '0;
      prev_se_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en)
        scale_r <= cfg_scale_divisor;
      if (cmd.upd_end && (pend_e_r > open_e_r))
        open_e_r <= pend_e_r;
      if (cmd.install) begin
        open_s_r     <= pend_s_r;
        open_e_r     <= pend_e_r;
        open_valid_r <= 1'b1;
      end
      if (out_ready)
        out_valid_r <= 1'b0;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
        if (emit_last_r) begin
          // end of list: start the next one from scratch
          open_valid_r <= 1'b0;
          open_s_r     <= '0;
          open_e_r     <= '0;
          prev_me_r    <= '0;
          prev_se_r    <= '0;
        end else begin
          prev_me_r <= emit_e_r;
          prev_se_r <= send;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pend_s_r    <= in_interval_start;
      pend_e_r    <= in_interval_end;
      pend_last_r <= in_is_last;
    end
    if (cmd.ld_emit) begin
      emit_s_r    <= open_s_r;
      emit_e_r    <= open_e_r;
      emit_last_r <= cmd.emit_last;
    end
    if (cmd.gap_cap) begin
      sgap_r   <= div_q;
      sstart_r <= div_q + prev_se_r;
    end
    if (cmd.len_cap)
      slen_r <= div_q + COORD_W'(div_rem != '0);
    if (cmd.out_load) begin
      o_ms_r   <= emit_s_r;
      o_me_r   <= emit_e_r;
      o_gap_r  <= sgap_r;
      o_len_r  <= slen_r;
      o_ss_r   <= sstart_r;
      o_se_r   <= send;
      o_last_r <= emit_last_r;
    end
  end

  assign sts.merge      = open_valid_r && (open_e_r >= pend_s_r);
  assign sts.open_valid = open_valid_r;
  assign sts.pend_last  = pend_last_r;
  assign sts.emit_last  = emit_last_r;
  assign sts.div_done   = div_done;
  assign sts.out_free   = out_free;

  assign out_valid         = out_valid_r;
  assign out_merged_start  = o_ms_r;
  assign out_merged_end    = o_me_r;
  assign out_scaled_gap    = o_gap_r;
  assign out_scaled_length = o_len_r;
  assign out_scaled_start  = o_ss_r;
  assign out_scaled_end    = o_se_r;
  assign out_last_out      = o_last_r;

  `MSI_ASSERT_NOW(a_load_only_when_free, cmd.out_load, out_free)
  `MSI_ASSERT_NOW(a_no_start_while_busy, cmd.gap_start || cmd.len_start, !div_busy)
  `MSI_ASSERT_NEXT(a_last_clears_list, cmd.out_load && emit_last_r,
                   !open_valid_r && (prev_me_r == '0) && (prev_se_r == '0))
  `MSI_ASSERT_NEXT(a_end_chains_start, cmd.out_load, o_se_r == o_ss_r + o_len_r)

endmodule

/* src/msi_ctrl.sv */
// Controller FSM: sequences merge, close, flush and the two divisions.
// Depends on msi_pkg.
module msi_ctrl
  import msi_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n)
      state_r <= ST_IDLE;
    else
      state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts.merge) begin
          cmd.upd_end = 1'b1;
          state_nxt   = sts.pend_last ? ST_FLUSH : ST_IDLE;
        end else if (sts.open_valid) begin
          // close the open interval, pending one takes its place
          cmd.ld_emit = 1'b1;
          cmd.install = 1'b1;
          state_nxt   = ST_GAP;
        end else begin
          cmd.install = 1'b1;
          state_nxt   = sts.pend_last ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        cmd.ld_emit   = 1'b1;
        cmd.emit_last = 1'b1;
        state_nxt     = ST_GAP;
      end
      ST_GAP: begin
        cmd.gap_start = 1'b1;
        state_nxt     = ST_GWAIT;
      end
      ST_GWAIT: begin
        if (sts.div_done) begin
          cmd.gap_cap = 1'b1;
          state_nxt   = ST_LEN;
        end
      end
      ST_LEN: begin
        cmd.len_start = 1'b1;
        state_nxt     = ST_LWAIT;
      end
      ST_LWAIT: begin
        if (sts.div_done) begin
          cmd.len_cap = 1'b1;
          state_nxt   = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = (!sts.emit_last && sts.pend_last) ? ST_FLUSH : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* src/merge_and_scale_intervals.sv */
// Sorted interval merge with scaled gap/length. Depends on msi_pkg, msi_ctrl, msi_dp.
// Each emitted interval takes two passes of the shared radix-2 divider plus sequencing.
// A new transaction is taken only after the controller is done with the previous one.
// Reset: synchronous active-low rst_n; no open interval, chained ends 0, scale 1.
module merge_and_scale_intervals
  import msi_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_wr_en,
  input  logic [SCALE_W-1:0] cfg_scale_divisor,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [COORD_W-1:0] in_interval_start,
  input  logic [COORD_W-1:0] in_interval_end,
  input  logic               in_is_last,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COORD_W-1:0] out_merged_start,
  output logic [COORD_W-1:0] out_merged_end,
  output logic [COORD_W-1:0] out_scaled_gap,
  output logic [COORD_W-1:0] out_scaled_length,
  output logic [COORD_W-1:0] out_scaled_start,
  output logic [COORD_W-1:0] out_scaled_end,
  output logic               out_last_out
);

  // The controller takes one transaction at a time. An input merges into the
  // open interval, becomes it when none is open, or closes it (one result);
  // the last input of a list also flushes the open interval (one more result).
  // Each result runs the gap then the length through the divider; the
  // finished result waits in the output register while a new transaction is taken.

  cmd_t cmd;
  sts_t sts;

  msi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  msi_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_scale_divisor (cfg_scale_divisor),
    .in_interval_start (in_interval_start),
    .in_interval_end   (in_interval_end),
    .in_is_last        (in_is_last),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_merged_start  (out_merged_start),
    .out_merged_end    (out_merged_end),
    .out_scaled_gap    (out_scaled_gap),
    .out_scaled_length (out_scaled_length),
    .out_scaled_start  (out_scaled_start),
    .out_scaled_end    (out_scaled_end),
    .out_last_out      (out_last_out)
  );

endmodule
